// ===== hw/rtl/tfd_pkg.sv =====
// Shared types, constants and arithmetic helpers for the two-tap stereo
// feedback delay. Used by tfd_lane, tfd_merge and the top level.
`timescale 1ns / 1ps
`default_nettype none

package tfd_pkg;

  localparam int unsigned SAMPLE_BITS  = 16;
  localparam int unsigned DEPTH        = 131072;
  localparam int unsigned ADDR_W       = $clog2(DEPTH);
  localparam int unsigned DELAY_W      = 17;
  localparam int unsigned GAIN_W       = 16;
  localparam int unsigned ECHO_LEVEL_W = 13;
  // 2 * x * gain, signed
  localparam int unsigned DRY_W        = SAMPLE_BITS + GAIN_W + 2;
  // 0.1 * (c0 + c1), signed
  localparam int unsigned ECHO_W       = SAMPLE_BITS + 1 + ECHO_LEVEL_W + 1;
  // (left_out + right_out) * feedback_gain, signed
  localparam int unsigned FB_W         = SAMPLE_BITS + 1 + GAIN_W + 1;
  localparam int unsigned ACC_W        = DRY_W + 2;
  localparam int unsigned MIX_SHIFT    = 15;
  localparam int unsigned FB_SHIFT     = 14;

  typedef logic signed [SAMPLE_BITS-1:0]  smp_t;
  typedef logic        [ADDR_W-1:0]       addr_t;
  typedef logic        [DELAY_W-1:0]      delay_t;
  typedef logic        [GAIN_W-1:0]       gain_t;
  typedef logic signed [ECHO_LEVEL_W:0]   echo_lvl_t;
  typedef logic signed [DRY_W-1:0]        dry_t;
  typedef logic signed [ECHO_W-1:0]       echo_t;
  typedef logic signed [FB_W-1:0]         fb_t;
  typedef logic signed [ACC_W-1:0]        acc_t;

  // 0.1 in Q0.15
  localparam echo_lvl_t ECHO_LEVEL = echo_lvl_t'(3277);

  localparam acc_t SMAX = (acc_t'(1) <<< (SAMPLE_BITS - 1)) - acc_t'(1);
  localparam acc_t SMIN = -(acc_t'(1) <<< (SAMPLE_BITS - 1));

  typedef struct packed {
    smp_t left_in;
    smp_t right_in;
  } in_t;

  typedef struct packed {
    smp_t left_out;
    smp_t right_out;
  } out_t;

  // One store entry: channel 0 in the low half.
  typedef struct packed {
    smp_t ch1;
    smp_t ch0;
  } pair_t;

  // Step strobes from the sequencer to the lanes and the merge stage.
  typedef struct packed {
    logic rd;
    logic mix;
    logic sum;
    logic fb;
    logic wb;
  } ctrl_t;

  // Round half up, then drop s fraction bits.
  function automatic acc_t rnd_shr(acc_t v, int unsigned s);
    acc_t w;
    w = v + (acc_t'(1) <<< (s - 1));
    return w >>> s;
  endfunction

  function automatic smp_t sat(acc_t v);
    smp_t r;
    if (v > SMAX) begin
      r = smp_t'(SMAX);
    end else if (v < SMIN) begin
      r = smp_t'(SMIN);
    end else begin
      r = smp_t'(v);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tfd_lane.sv =====
// One echo lane: a stereo echo store with its tap read, dry gain and echo mix.
// Depends on tfd_pkg for types, widths and the rounding helpers.
`timescale 1ns / 1ps
`default_nettype none

module tfd_lane (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire tfd_pkg::ctrl_t  ctrl_i,
  input  wire tfd_pkg::addr_t  raddr_i,
  input  wire logic            bypass_i,
  input  wire logic            fill_ok_i,
  input  wire tfd_pkg::pair_t  pair_i,
  input  wire tfd_pkg::smp_t   dry_smp_i,
  input  wire tfd_pkg::gain_t  dry_gain_i,
  input  wire tfd_pkg::addr_t  waddr_i,
  input  wire tfd_pkg::pair_t  wdata_i,
  output tfd_pkg::smp_t        out_o
);

  tfd_pkg::pair_t mem_q [tfd_pkg::DEPTH];

  tfd_pkg::pair_t rdata_q;
  logic           hit_q;
  logic           ok_q;
  tfd_pkg::dry_t  dry_q;
  tfd_pkg::echo_t echo_q;
  tfd_pkg::smp_t  out_q;

  tfd_pkg::pair_t                     tap;
  logic signed [tfd_pkg::SAMPLE_BITS:0]   csum;
  logic signed [tfd_pkg::GAIN_W:0]        gain_s;
  tfd_pkg::dry_t                      dry_d;
  tfd_pkg::echo_t                     echo_d;
  tfd_pkg::acc_t                      acc;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wb) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (ctrl_i.rd) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  always_comb begin
    // Zero delay reads the beat itself; never-written entries read as zero.
    if (hit_q) begin
      tap = pair_i;
    end else if (ok_q) begin
      tap = rdata_q;
    end else begin
      tap = '0;
    end
    csum     = {tap.ch0[tfd_pkg::SAMPLE_BITS-1], tap.ch0}
             + {tap.ch1[tfd_pkg::SAMPLE_BITS-1], tap.ch1};
    echo_d   = tfd_pkg::echo_t'(csum) * tfd_pkg::echo_t'(tfd_pkg::ECHO_LEVEL);
    gain_s   = $signed({1'b0, dry_gain_i});
    dry_d    = (tfd_pkg::dry_t'(dry_smp_i) * tfd_pkg::dry_t'(gain_s)) <<< 1;
    acc      = tfd_pkg::acc_t'(dry_q) + tfd_pkg::acc_t'(echo_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
      ok_q  <= 1'b0;
    end else if (ctrl_i.rd) begin
      hit_q <= bypass_i;
      ok_q  <= fill_ok_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mix) begin
      dry_q  <= dry_d;
      echo_q <= echo_d;
    end
    if (ctrl_i.sum) begin
      out_q <= tfd_pkg::sat(tfd_pkg::rnd_shr(acc, tfd_pkg::MIX_SHIFT));
    end
  end

  assign out_o = out_q;

endmodule

`default_nettype wire

// ===== hw/rtl/tfd_merge.sv =====
// Merge stage: combines both lane outputs into the feedback term and forms
// the write-back entries of both stores. Depends on tfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tfd_merge (
  input  wire logic            clk_i,
  input  wire tfd_pkg::ctrl_t  ctrl_i,
  input  wire tfd_pkg::smp_t   lo_i,
  input  wire tfd_pkg::smp_t   ro_i,
  input  wire tfd_pkg::gain_t  fb_gain_i,
  input  wire tfd_pkg::pair_t  pair_i,
  output tfd_pkg::pair_t       wdata_a_o,
  output tfd_pkg::pair_t       wdata_b_o
);

  tfd_pkg::fb_t                          prod_q;
  tfd_pkg::fb_t                          prod_d;
  logic signed [tfd_pkg::SAMPLE_BITS:0]  lr_sum;
  logic signed [tfd_pkg::GAIN_W:0]       gain_s;
  tfd_pkg::acc_t                         fbr;

  always_comb begin
    lr_sum = {lo_i[tfd_pkg::SAMPLE_BITS-1], lo_i} + {ro_i[tfd_pkg::SAMPLE_BITS-1], ro_i};
    gain_s = $signed({1'b0, fb_gain_i});
    prod_d = tfd_pkg::fb_t'(lr_sum) * tfd_pkg::fb_t'(gain_s);
    fbr    = tfd_pkg::rnd_shr(tfd_pkg::acc_t'(prod_q), tfd_pkg::FB_SHIFT);
    // Feed back into channel 0 of store A and channel 1 of store B.
    wdata_a_o.ch0 = tfd_pkg::sat(tfd_pkg::acc_t'(pair_i.ch0) + fbr);
    wdata_a_o.ch1 = pair_i.ch1;
    wdata_b_o.ch0 = pair_i.ch0;
    wdata_b_o.ch1 = tfd_pkg::sat(tfd_pkg::acc_t'(pair_i.ch1) + fbr);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.fb) begin
      prod_q <= prod_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/two_tap_stereo_feedback_delay_top.sv =====
// Two-tap stereo feedback delay: sequencer, registers, write position and
// output register around two tfd_lane instances and tfd_merge. Uses tfd_pkg.
//
// Usage:
//   Input channel in_valid_i / in_stall_o / in_data_i carries one stereo
//   sample pair per beat. Output channel out_valid_o / out_stall_i /
//   out_data_o returns one stereo result per beat, in order.
//   Registers are written through cfg_we_i / cfg_idx_i / cfg_data_i:
//   0 dry gain, 1 first tap delay, 2 second tap delay, 3 feedback gain.
//   Write them only while no beat is in flight.
//   Each beat runs the sequence of tap read, mix multiply, round, feedback
//   multiply and store write-back through the single write port of each
//   store; the result enters the output register at write-back, and a new
//   beat is taken only after the previous one's write-back.
//   A stalled result sits in the output register; the next beat is still
//   taken and processed, and its write-back waits until the register frees.
//   Reset clears the write position and loads the register defaults. The
//   stores are not swept: entries not yet written since reset read as zero,
//   tracked by the write position and a wrap flag, so the block is ready
//   as soon as reset is released.
`timescale 1ns / 1ps
`default_nettype none

module two_tap_stereo_feedback_delay_top (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire tfd_pkg::in_t            in_data_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output tfd_pkg::out_t                out_data_o,
  input  wire logic                    cfg_we_i,
  input  wire logic [1:0]              cfg_idx_i,
  input  wire logic [tfd_pkg::DELAY_W-1:0] cfg_data_i
);

  typedef enum logic [1:0] {
    CFG_DRY_GAIN  = 2'd0,
    CFG_DELAY_ONE = 2'd1,
    CFG_DELAY_TWO = 2'd2,
    CFG_FB_GAIN   = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MIX,
    ST_SUM,
    ST_FB,
    ST_WB
  } state_e;

  state_e          state_q;
  tfd_pkg::gain_t  dry_gain_q;
  tfd_pkg::delay_t delay_one_q;
  tfd_pkg::delay_t delay_two_q;
  tfd_pkg::gain_t  fb_gain_q;
  tfd_pkg::addr_t  wp_q;
  logic            wrapped_q;
  tfd_pkg::pair_t  pair_q;
  logic            out_valid_q;
  tfd_pkg::out_t   out_q;

  tfd_pkg::ctrl_t  ctrl;
  logic            accept;
  logic            wb_go;
  tfd_pkg::addr_t  tap_a;
  tfd_pkg::addr_t  tap_b;
  tfd_pkg::smp_t   lo;
  tfd_pkg::smp_t   ro;
  tfd_pkg::pair_t  wdata_a;
  tfd_pkg::pair_t  wdata_b;

  function automatic tfd_pkg::addr_t tap_pos(tfd_pkg::delay_t delay, tfd_pkg::addr_t wp);
    tfd_pkg::addr_t dc;
    tfd_pkg::addr_t pos;
    if (32'(delay) > 32'(tfd_pkg::DEPTH - 1)) begin
      dc = tfd_pkg::addr_t'(tfd_pkg::DEPTH - 1);
    end else begin
      dc = tfd_pkg::addr_t'(delay);
    end
    if (wp >= dc) begin
      pos = wp - dc;
    end else begin
      pos = tfd_pkg::addr_t'(32'(wp) + 32'(tfd_pkg::DEPTH) - 32'(dc));
    end
    return pos;
  endfunction

  always_comb begin
    accept    = in_valid_i && (state_q == ST_IDLE);
    wb_go     = (state_q == ST_WB) && (!out_valid_q || !out_stall_i);
    ctrl.rd   = accept;
    ctrl.mix  = (state_q == ST_MIX);
    ctrl.sum  = (state_q == ST_SUM);
    ctrl.fb   = (state_q == ST_FB);
    ctrl.wb   = wb_go;
    tap_a     = tap_pos(delay_one_q, wp_q);
    tap_b     = tap_pos(delay_two_q, wp_q);
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dry_gain_q  <= tfd_pkg::gain_t'(16384);
      delay_one_q <= tfd_pkg::delay_t'(24000);
      delay_two_q <= tfd_pkg::delay_t'(9600);
      fb_gain_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_DRY_GAIN:  dry_gain_q  <= tfd_pkg::gain_t'(cfg_data_i);
        CFG_DELAY_ONE: delay_one_q <= cfg_data_i;
        CFG_DELAY_TWO: delay_two_q <= cfg_data_i;
        CFG_FB_GAIN:   fb_gain_q   <= tfd_pkg::gain_t'(cfg_data_i);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wp_q        <= '0;
      wrapped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (wb_go) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_MIX;
          end
        end
        ST_MIX: state_q <= ST_SUM;
        ST_SUM: state_q <= ST_FB;
        ST_FB:  state_q <= ST_WB;
        ST_WB: begin
          // Hold until the output register can take the result.
          if (wb_go) begin
            state_q     <= ST_IDLE;
            if (32'(wp_q) == 32'(tfd_pkg::DEPTH - 1)) begin
              wp_q      <= '0;
              wrapped_q <= 1'b1;
            end else begin
              wp_q <= wp_q + tfd_pkg::addr_t'(1);
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pair_q.ch0 <= in_data_i.left_in;
      pair_q.ch1 <= in_data_i.right_in;
    end
    if (wb_go) begin
      out_q.left_out  <= lo;
      out_q.right_out <= ro;
    end
  end

  tfd_lane u_lane_a (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .raddr_i    (tap_a),
    .bypass_i   (tap_a == wp_q),
    .fill_ok_i  (wrapped_q || (tap_a < wp_q)),
    .pair_i     (pair_q),
    .dry_smp_i  (pair_q.ch0),
    .dry_gain_i (dry_gain_q),
    .waddr_i    (wp_q),
    .wdata_i    (wdata_a),
    .out_o      (lo)
  );

  tfd_lane u_lane_b (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .raddr_i    (tap_b),
    .bypass_i   (tap_b == wp_q),
    .fill_ok_i  (wrapped_q || (tap_b < wp_q)),
    .pair_i     (pair_q),
    .dry_smp_i  (pair_q.ch1),
    .dry_gain_i (dry_gain_q),
    .waddr_i    (wp_q),
    .wdata_i    (wdata_b),
    .out_o      (ro)
  );

  tfd_merge u_merge (
    .clk_i     (clk_i),
    .ctrl_i    (ctrl),
    .lo_i      (lo),
    .ro_i      (ro),
    .fb_gain_i (fb_gain_q),
    .pair_i    (pair_q),
    .wdata_a_o (wdata_a),
    .wdata_b_o (wdata_b)
  );

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_MIX))
    else $error("accepted beat did not start the mix step");

  a_result_from_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_WB))
    else $error("result appeared without a write-back step");

  a_wp_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wb_go |=> ((wp_q == $past(wp_q) + tfd_pkg::addr_t'(1)) || (wp_q == '0)))
    else $error("write position did not advance by one");

  a_wp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !wb_go |=> $stable(wp_q))
    else $error("write position moved without a write-back");

  a_wrap_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wrapped_q |=> wrapped_q)
    else $error("wrap flag cleared outside reset");

endmodule

`default_nettype wire

// ===== dv/two_tap_stereo_feedback_delay_top_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for two_tap_stereo_feedback_delay_top: a scoreboard class keeps its
// own copy of both echo stores and predicts every output beat; plain tasks drive the ports.
// Depends on tfd_pkg and the top-level RTL only.

typedef enum logic [1:0] {
  REG_DRY_GAIN,
  REG_DELAY_ONE,
  REG_DELAY_TWO,
  REG_FEEDBACK_GAIN
} reg_idx_e;

typedef logic [tfd_pkg::DELAY_W-1:0] cfg_word_t;

class echo_scoreboard;
  localparam int MAX_PRINTED = 40;

  tfd_pkg::pair_t  store_a [tfd_pkg::DEPTH];
  tfd_pkg::pair_t  store_b [tfd_pkg::DEPTH];
  int unsigned     wr_pos;
  tfd_pkg::gain_t  dry_gain;
  tfd_pkg::delay_t delay_one;
  tfd_pkg::delay_t delay_two;
  tfd_pkg::gain_t  fb_gain;
  tfd_pkg::out_t   echo_expected_q [$];
  int              errors;
  int              beats_seen;

  function new();
    foreach (store_a[i]) begin
      store_a[i] = '0;
      store_b[i] = '0;
    end
    wr_pos     = 0;
    dry_gain   = tfd_pkg::gain_t'(16384);
    delay_one  = tfd_pkg::delay_t'(24000);
    delay_two  = tfd_pkg::delay_t'(9600);
    fb_gain    = '0;
    errors     = 0;
    beats_seen = 0;
  endfunction

  function void write_reg(reg_idx_e idx, cfg_word_t val);
    case (idx)
      REG_DRY_GAIN:      dry_gain  = val[tfd_pkg::GAIN_W-1:0];
      REG_DELAY_ONE:     delay_one = val;
      REG_DELAY_TWO:     delay_two = val;
      REG_FEEDBACK_GAIN: fb_gain   = val[tfd_pkg::GAIN_W-1:0];
      default: ;
    endcase
  endfunction

  function int unsigned write_position();
    return wr_pos;
  endfunction

  function int pending();
    return echo_expected_q.size();
  endfunction

  // Round half up, then drop s fraction bits (floor on the biased value).
  function longint round_shr(longint v, int unsigned s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function longint clamp(longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (tfd_pkg::SAMPLE_BITS - 1)) - 1;
    lo = -(longint'(1) <<< (tfd_pkg::SAMPLE_BITS - 1));
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function int unsigned tap_of(tfd_pkg::delay_t delay);
    int unsigned d;
    d = (delay > tfd_pkg::DEPTH - 1) ? tfd_pkg::DEPTH - 1 : delay;
    return (wr_pos >= d) ? wr_pos - d : wr_pos + tfd_pkg::DEPTH - d;
  endfunction

  function void absorb_pair(tfd_pkg::in_t d);
    int unsigned   wp;
    int unsigned   ta;
    int unsigned   tb;
    longint        echo_a;
    longint        echo_b;
    longint        lo;
    longint        ro;
    longint        fb;
    tfd_pkg::out_t want;
    wp = wr_pos;
    // land the dry pair first so a zero delay reads it back
    store_a[wp] = {d.right_in, d.left_in};
    store_b[wp] = {d.right_in, d.left_in};
    ta = tap_of(delay_one);
    tb = tap_of(delay_two);
    echo_a = longint'(store_a[ta].ch0) + longint'(store_a[ta].ch1);
    echo_b = longint'(store_b[tb].ch0) + longint'(store_b[tb].ch1);
    lo = clamp(round_shr(2 * longint'(d.left_in) * longint'(dry_gain)
                         + longint'(tfd_pkg::ECHO_LEVEL) * echo_a, tfd_pkg::MIX_SHIFT));
    ro = clamp(round_shr(2 * longint'(d.right_in) * longint'(dry_gain)
                         + longint'(tfd_pkg::ECHO_LEVEL) * echo_b, tfd_pkg::MIX_SHIFT));
    fb = round_shr((lo + ro) * longint'(fb_gain), tfd_pkg::FB_SHIFT);
    store_a[wp].ch0 = tfd_pkg::smp_t'(clamp(longint'(store_a[wp].ch0) + fb));
    store_b[wp].ch1 = tfd_pkg::smp_t'(clamp(longint'(store_b[wp].ch1) + fb));
    wr_pos = (wp + 1 == tfd_pkg::DEPTH) ? 0 : wp + 1;
    want.left_out  = tfd_pkg::smp_t'(lo);
    want.right_out = tfd_pkg::smp_t'(ro);
    echo_expected_q.push_back(want);
  endfunction

  task report(string msg);
    errors++;
    if (errors <= MAX_PRINTED) $display("%0t ns  mismatch: %s", $time, msg);
  endtask

  task check_pair(tfd_pkg::out_t got);
    tfd_pkg::out_t want;
    beats_seen++;
    if (echo_expected_q.size() == 0) begin
      report($sformatf("beat %0d: result with nothing pending", beats_seen));
    end else begin
      want = echo_expected_q.pop_front();
      if (got.left_out !== want.left_out)
        report($sformatf("beat %0d: left_out %0d, predicted %0d", beats_seen,
                         $signed(got.left_out), $signed(want.left_out)));
      if (got.right_out !== want.right_out)
        report($sformatf("beat %0d: right_out %0d, predicted %0d", beats_seen,
                         $signed(got.right_out), $signed(want.right_out)));
    end
  endtask
endclass

module two_tap_stereo_feedback_delay_top_test;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int TAIL_CYCLES = 12;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_BEATS = 85;

  logic          clk       = 1'b0;
  logic          rst_n     = 1'b0;
  logic          in_valid  = 1'b0;
  logic          in_stall;
  tfd_pkg::in_t  in_data   = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  tfd_pkg::out_t out_data;
  logic          cfg_we    = 1'b0;
  reg_idx_e      cfg_idx   = REG_DRY_GAIN;
  cfg_word_t     cfg_data  = '0;

  bit rx_free  = 1'b0;
  bit hold_req = 1'b0;

  echo_scoreboard sb = new();

  two_tap_stereo_feedback_delay_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // check the output side first so a stray result never meets a fresh prediction
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_pair(out_data);
      if (in_valid && !in_stall) sb.absorb_pair(in_data);
    end
  end

  // Receiver: random stall runs, a free-running mode, and a long counted hold.
  initial begin
    int stall_left;
    int free_left;
    int hold_left;
    bit stall_next;
    stall_left = 0;
    free_left  = 0;
    hold_left  = 0;
    forever begin
      @(negedge clk);
      if (hold_req && hold_left == 0) hold_left = HOLD_CYCLES;
      if (hold_left > 0) begin
        stall_next = 1'b1;
        hold_left--;
        if (hold_left == 0) hold_req = 1'b0;
      end else if (rx_free) begin
        stall_next = 1'b0;
      end else if (stall_left > 0) begin
        stall_next = 1'b1;
        stall_left--;
      end else if (free_left > 0) begin
        stall_next = 1'b0;
        free_left--;
      end else begin
        free_left  = ($urandom_range(0, 11) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 6);
        stall_left = ($urandom_range(0, 11) == 0) ? $urandom_range(15, 45) : $urandom_range(0, 3);
        stall_next = 1'b0;
      end
      out_stall <= stall_next;
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 24) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 4);
    return 0;
  endfunction

  function automatic tfd_pkg::smp_t rand_sample();
    tfd_pkg::smp_t s;
    case ($urandom_range(0, 7))
      0:       s = tfd_pkg::smp_t'(16'h7fff);
      1:       s = tfd_pkg::smp_t'(16'h8000);
      2:       s = tfd_pkg::smp_t'(int'($urandom_range(0, 511)) - 256);
      default: s = tfd_pkg::smp_t'($urandom);
    endcase
    return s;
  endfunction

  function automatic tfd_pkg::in_t rand_pair();
    tfd_pkg::in_t d;
    d.left_in  = rand_sample();
    d.right_in = rand_sample();
    return d;
  endfunction

  function automatic cfg_word_t pick_gain();
    cfg_word_t g;
    case ($urandom_range(0, 7))
      0:       g = '0;
      1:       g = cfg_word_t'(16384);
      2:       g = cfg_word_t'(32768);
      3:       g = cfg_word_t'(16'hffff);
      4:       g = cfg_word_t'($urandom_range(0, 32768));
      5:       g = cfg_word_t'($urandom);
      default: g = cfg_word_t'($urandom_range(0, 20000));
    endcase
    return g;
  endfunction

  function automatic cfg_word_t pick_delay();
    cfg_word_t d;
    case ($urandom_range(0, 9))
      0:       d = '0;
      1:       d = cfg_word_t'(tfd_pkg::DEPTH - 1);
      2, 3, 4: d = cfg_word_t'($urandom_range(1, 16));
      5, 6:    d = cfg_word_t'($urandom_range(17, 64));
      7:       d = cfg_word_t'($urandom_range(65, 4000));
      default: d = cfg_word_t'($urandom);
    endcase
    return d;
  endfunction

  // Offer one beat after the idle gap given by gap; return once it is taken.
  task automatic send_pair(tfd_pkg::in_t d, int gap);
    int k;
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      for (k = 1; k < gap; k++) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= d;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
  endtask

  task automatic stop_sending();
    @(negedge clk) in_valid <= 1'b0;
  endtask

  task automatic drain_results();
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_e idx, cfg_word_t val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk) sb.write_reg(idx, val);
  endtask

  task automatic apply_settings(cfg_word_t dry, cfg_word_t d1, cfg_word_t d2, cfg_word_t fb);
    stop_sending();
    drain_results();
    write_reg(REG_DRY_GAIN, dry);
    write_reg(REG_DELAY_ONE, d1);
    write_reg(REG_DELAY_TWO, d2);
    write_reg(REG_FEEDBACK_GAIN, fb);
    @(negedge clk) cfg_we <= 1'b0;
  endtask

  // Full-scale corners; packed vector order is {left_in, right_in}.
  task automatic send_corner_pairs();
    tfd_pkg::in_t d;
    int           k;
    for (k = 0; k < 7; k++) begin
      case (k)
        0:       d = {16'h7fff, 16'h7fff};
        1:       d = {16'h8000, 16'h8000};
        2:       d = {16'h0000, 16'h0000};
        3:       d = {16'h7fff, 16'h8000};
        4:       d = {16'h8000, 16'h7fff};
        5:       d = {16'hffff, 16'h0001};
        default: d = {16'h0001, 16'hffff};
      endcase
      send_pair(d, pick_gap());
    end
  endtask

  task automatic run_phase(int beats, bit pressure, bit pause, bit no_idle);
    int i;
    int j;
    if (no_idle) rx_free = 1'b1;
    for (i = 0; i < beats; i++) begin
      if (pressure && i == beats / 3) begin
        // hold the output while beats keep coming so the block backs up
        hold_req = 1'b1;
        for (j = 0; j < 24; j++) send_pair(rand_pair(), 0);
      end
      if (pause && i == beats / 2) begin
        stop_sending();
        drain_results();
      end
      send_pair(rand_pair(), no_idle ? 0 : pick_gap());
    end
    rx_free = 1'b0;
  endtask

  initial begin
    int p;
    repeat (10) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // reset defaults, then saturation with zero and unit delays, then long tap
    send_corner_pairs();
    apply_settings(cfg_word_t'(16'hffff), cfg_word_t'(0), cfg_word_t'(1),
                   cfg_word_t'(16'hffff));
    send_corner_pairs();
    apply_settings(cfg_word_t'(0), cfg_word_t'(tfd_pkg::DEPTH - 1), cfg_word_t'(0),
                   cfg_word_t'(32768));
    send_corner_pairs();

    apply_settings(cfg_word_t'(0), cfg_word_t'(0), cfg_word_t'(0), cfg_word_t'(0));
    run_phase(PHASE_BEATS, 1'b0, 1'b0, 1'b0);
    for (p = 1; p < 8; p++) begin
      apply_settings(pick_gain(), pick_delay(), pick_delay(), pick_gain());
      run_phase(PHASE_BEATS, p == 2, p == 4, p == 5);
    end

    apply_settings(cfg_word_t'(32768), cfg_word_t'(tfd_pkg::DEPTH - 1),
                   cfg_word_t'(tfd_pkg::DEPTH - 1), cfg_word_t'(32768));
    run_phase(PHASE_BEATS, 1'b0, 1'b0, 1'b0);
    for (p = 1; p < 8; p++) begin
      apply_settings(pick_gain(), pick_delay(), pick_delay(), pick_gain());
      run_phase(PHASE_BEATS, p == 3, p == 1, p == 6);
    end

    stop_sending();
    drain_results();
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
